### sv/top_k_score_selector_core_assert.svh
// Assertion macros used by the selector RTL.
// Define ASSERT_OFF to compile the checks out.
`ifndef TOP_K_SCORE_SELECTOR_CORE_ASSERT_SVH
`define TOP_K_SCORE_SELECTOR_CORE_ASSERT_SVH

`ifndef ASSERT_OFF

// Check a property on every clock edge outside reset.
`define TKS_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define TKS_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define TKS_ASSERT(label, clk, rst, prop, msg)
`define TKS_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

### sv/tks_pkg.sv
package tks_pkg;

  // Default sizing
  localparam int DEFAULT_MAX_KEEP    = 64;
  localparam int DEFAULT_COUNT_WIDTH = 16;

  // Field widths
  localparam int KEEP_W  = 7;
  localparam int RANK_W  = 6;
  localparam int SCORE_W = 32;
  localparam int DATE_W  = 32;

  // Register port
  localparam int ADDR_W      = 3;
  localparam int DATA_W      = 32;
  localparam int REG_SEL_BIT = 2;

  localparam logic REG_ASCENDING  = 1'b0;
  localparam logic REG_KEEP_COUNT = 1'b1;

  localparam logic              RESET_ASCENDING  = 1'b1;
  localparam logic [KEEP_W-1:0] RESET_KEEP_COUNT = 7'd64;

  // Result status codes
  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_SHORT = 1'b1;

  typedef struct packed {
    logic signed [SCORE_W-1:0] score;
    logic [DATE_W-1:0]         candidate_date;
    logic                      score_is_nan;
    logic                      end_of_target;
  } cand_t;

  typedef struct packed {
    logic [RANK_W-1:0]         rank;
    logic signed [SCORE_W-1:0] best_score;
    logic [DATE_W-1:0]         best_date;
    logic                      status;
    logic                      saw_nan;
    logic                      last_result;
  } result_t;

  typedef struct packed {
    logic              ascending_order;
    logic [KEEP_W-1:0] keep_count;
  } cfg_t;

  typedef struct packed {
    logic signed [SCORE_W-1:0] score;
    logic [DATE_W-1:0]         date;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

### sv/tks_cfg.sv
module tks_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tks_pkg::ADDR_W-1:0]  paddr,
  input  logic [tks_pkg::DATA_W-1:0]  pwdata,
  output logic [tks_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output tks_pkg::cfg_t               cfg
);
  import tks_pkg::*;

  logic              ascending_order;
  logic [KEEP_W-1:0] keep_count;
  logic              wr;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite & pready;

  // Write the selected register on the access phase
  always_ff @(posedge clk) begin
    if (rst) begin
      ascending_order <= RESET_ASCENDING;
      keep_count      <= RESET_KEEP_COUNT;
    end else if (wr) begin
      case (paddr[REG_SEL_BIT])
        REG_ASCENDING:  ascending_order <= pwdata[0];
        REG_KEEP_COUNT: keep_count      <= pwdata[KEEP_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    prdata = '0;
    case (paddr[REG_SEL_BIT])
      REG_ASCENDING:  prdata[0]          = ascending_order;
      REG_KEEP_COUNT: prdata[KEEP_W-1:0] = keep_count;
      default:        prdata             = '0;
    endcase
  end

  assign cfg.ascending_order = ascending_order;
  assign cfg.keep_count      = keep_count;

endmodule

### sv/tks_ram.sv
module tks_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### sv/tks_seq.sv
`include "top_k_score_selector_core_assert.svh"

module tks_seq #(
  parameter int MAX_KEEP    = tks_pkg::DEFAULT_MAX_KEEP,
  parameter int COUNT_WIDTH = tks_pkg::DEFAULT_COUNT_WIDTH,
  parameter int IDX_W       = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  tks_pkg::cfg_t        cfg,
  input  logic                 cand_valid,
  input  tks_pkg::cand_t       cand,
  output logic                 cand_stall,
  output logic                 res_valid,
  output tks_pkg::result_t     res,
  input  logic                 res_stall,
  output logic                 wr_en,
  output logic [IDX_W-1:0]     wr_addr,
  output tks_pkg::entry_t      wr_data,
  output logic [IDX_W-1:0]     rd_addr,
  input  tks_pkg::entry_t      rd_data
);
  import tks_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_CHECK  = 3'd1;
  localparam logic [2:0] ST_WALK   = 3'd2;
  localparam logic [2:0] ST_PLACE  = 3'd3;
  localparam logic [2:0] ST_FINISH = 3'd4;
  localparam logic [2:0] ST_EMIT   = 3'd5;
  localparam logic [2:0] ST_ERR    = 3'd6;

  logic [2:0]             state;
  logic [2:0]             state_next;
  logic [IDX_W-1:0]       idx;
  logic [IDX_W-1:0]       idx_next;
  logic [COUNT_WIDTH-1:0] count;
  logic [COUNT_WIDTH-1:0] count_next;
  logic                   nan_seen;
  logic                   nan_seen_next;
  cand_t                  item;

  logic [KEEP_W-1:0]      k;
  logic [IDX_W-1:0]       k_last;
  logic [IDX_W-1:0]       cnt_last;
  logic                   full;
  logic                   better;
  logic                   out_free;
  logic                   res_load;
  result_t                res_data;
  entry_t                 new_entry;

  // Effective K, clamped to 1..MAX_KEEP
  always_comb begin
    if (cfg.keep_count == '0) begin
      k = KEEP_W'(1);
    end else if (int'(cfg.keep_count) > MAX_KEEP) begin
      k = KEEP_W'(MAX_KEEP);
    end else begin
      k = cfg.keep_count;
    end
  end

  assign k_last   = IDX_W'(k - KEEP_W'(1));
  assign cnt_last = IDX_W'(count - COUNT_WIDTH'(1));
  assign full     = (count >= COUNT_WIDTH'(k));

  // Shared compare unit: held candidate against the entry just read
  assign better = cfg.ascending_order ? (item.score < rd_data.score)
                                      : (item.score > rd_data.score);

  assign new_entry.score = item.score;
  assign new_entry.date  = item.candidate_date;

  assign out_free   = !res_valid || !res_stall;
  assign cand_stall = (state != ST_IDLE);

  // Sequencer
  always_comb begin
    state_next    = state;
    idx_next      = idx;
    count_next    = count;
    nan_seen_next = nan_seen;
    rd_addr       = '0;
    wr_en         = 1'b0;
    wr_addr       = idx;
    wr_data       = new_entry;
    res_load      = 1'b0;
    res_data      = '0;
    case (state)
      ST_IDLE: begin
        // Prefetch the entry the next candidate compares against first
        rd_addr = full ? k_last : cnt_last;
        if (cand_valid) begin
          nan_seen_next = nan_seen | cand.score_is_nan;
          if (!(&count)) begin
            count_next = count + COUNT_WIDTH'(1);
          end
          if (full) begin
            state_next = ST_CHECK;
          end else if (count == '0) begin
            idx_next   = '0;
            state_next = ST_PLACE;
          end else begin
            idx_next   = IDX_W'(count);
            state_next = ST_WALK;
          end
        end
      end
      ST_CHECK: begin
        // Full list: only a strictly better score displaces the worst entry
        rd_addr = k_last - IDX_W'(1);
        if (better) begin
          if (k_last == '0) begin
            idx_next   = '0;
            state_next = ST_PLACE;
          end else begin
            idx_next   = k_last;
            state_next = ST_WALK;
          end
        end else begin
          state_next = ST_FINISH;
        end
      end
      ST_WALK: begin
        // Shift worse entries down one slot until the insertion point
        wr_en = 1'b1;
        if (better) begin
          wr_data = rd_data;
          if (idx == IDX_W'(1)) begin
            idx_next   = '0;
            state_next = ST_PLACE;
          end else begin
            idx_next = idx - IDX_W'(1);
            rd_addr  = idx - IDX_W'(2);
          end
        end else begin
          state_next = ST_FINISH;
        end
      end
      ST_PLACE: begin
        wr_en      = 1'b1;
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        rd_addr  = '0;
        idx_next = '0;
        if (!item.end_of_target) begin
          state_next = ST_IDLE;
        end else if (full) begin
          state_next = ST_EMIT;
        end else begin
          state_next = ST_ERR;
        end
      end
      ST_EMIT: begin
        // Stream kept entries in rank order, one per free output slot
        rd_addr = idx;
        if (out_free) begin
          res_load             = 1'b1;
          res_data.rank        = RANK_W'(idx);
          res_data.best_score  = rd_data.score;
          res_data.best_date   = rd_data.date;
          res_data.status      = STATUS_OK;
          res_data.saw_nan     = nan_seen;
          res_data.last_result = (idx == k_last);
          if (idx == k_last) begin
            count_next    = '0;
            nan_seen_next = 1'b0;
            state_next    = ST_IDLE;
          end else begin
            idx_next = idx + IDX_W'(1);
            rd_addr  = idx + IDX_W'(1);
          end
        end
      end
      ST_ERR: begin
        if (out_free) begin
          res_load             = 1'b1;
          res_data.status      = STATUS_SHORT;
          res_data.saw_nan     = nan_seen;
          res_data.last_result = 1'b1;
          count_next           = '0;
          nan_seen_next        = 1'b0;
          state_next           = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      idx      <= '0;
      count    <= '0;
      nan_seen <= 1'b0;
    end else begin
      state    <= state_next;
      idx      <= idx_next;
      count    <= count_next;
      nan_seen <= nan_seen_next;
    end
  end

  // Hold the accepted candidate
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && cand_valid) begin
      item <= cand;
    end
  end

  // Output register: load on a free slot, drop valid after the transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res <= res_data;
    end
  end

  `TKS_ASSERT(a_accept_leaves_idle, clk, rst, (state == ST_IDLE && cand_valid) |=> (state != ST_IDLE), "accepted candidate did not start processing")
  `TKS_ASSERT(a_no_write_outside_insert, clk, rst, (state == ST_IDLE || state == ST_EMIT || state == ST_ERR) |-> !wr_en, "kept list written outside insertion")
  `TKS_ASSERT(a_walk_index_range, clk, rst, (state == ST_WALK) |-> (idx != '0 && idx <= k_last), "insertion walk index out of range")
  `TKS_ASSERT(a_last_clears_target, clk, rst, (res_load && res_data.last_result) |=> (state == ST_IDLE && count == '0 && !nan_seen), "target state not cleared after final result")
  `TKS_ASSERT_ALWAYS(a_reset_idle, clk, rst |=> (state == ST_IDLE && !res_valid), "reset did not return to idle")

endmodule

### sv/top_k_score_selector_core.sv
// Insertion: a target's first candidate is placed directly; later ones walk the
// kept-list memory one entry per cycle. On a full list a candidate not strictly
// better than the worst entry is dropped. At end of target a full list streams K
// results, one per cycle while the output is not stalled, else a short status.
// Reset clears the candidate count, the NaN flag, the output valid and the config
// (ascending order, K of 64); the kept list is not cleared and needs no sweep.
module top_k_score_selector_core #(
  parameter int MAX_KEEP    = tks_pkg::DEFAULT_MAX_KEEP,
  parameter int COUNT_WIDTH = tks_pkg::DEFAULT_COUNT_WIDTH
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tks_pkg::ADDR_W-1:0]  paddr,
  input  logic [tks_pkg::DATA_W-1:0]  pwdata,
  output logic [tks_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  input  logic                        cand_valid,
  output logic                        cand_stall,
  input  tks_pkg::cand_t              cand,
  output logic                        res_valid,
  input  logic                        res_stall,
  output tks_pkg::result_t            res
);
  import tks_pkg::*;

  localparam int IDX_W = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;

  cfg_t             cfg;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  entry_t           wr_data;
  logic [IDX_W-1:0] rd_addr;
  entry_t           rd_data;

  // Configuration registers
  tks_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Kept list storage
  tks_ram #(
    .DEPTH (MAX_KEEP),
    .WIDTH (ENTRY_W),
    .AW    (IDX_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Insertion and reporting sequencer
  tks_seq #(
    .MAX_KEEP    (MAX_KEEP),
    .COUNT_WIDTH (COUNT_WIDTH),
    .IDX_W       (IDX_W)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .cand_valid (cand_valid),
    .cand       (cand),
    .cand_stall (cand_stall),
    .res_valid  (res_valid),
    .res        (res),
    .res_stall  (res_stall),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data)
  );

endmodule
